FILE: rtl/avlm_pkg.sv
// ----------------------------------------------------------------------------
// avlm_pkg: shared types and constants for the vibration level meter
// Sequencer states, field widths and the fixed divisor of the level output.
// ----------------------------------------------------------------------------
package avlm_pkg;

  localparam int AXIS_W        = 16;  // raw accelerometer sample
  localparam int MAG_W         = 16;  // floor square root of the sum of squares
  localparam int SQ_W          = 32;  // sum of three squares
  localparam int ROOT_REM_W    = 19;  // root remainder after the two-bit shift
  localparam int TOTAL_W       = 21;  // deviation total
  localparam int LEVEL_W       = 15;  // output level
  localparam int LEVEL_DIVISOR = 50;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT,
    ST_HIST,
    ST_PREP,
    ST_DIVIDE,
    ST_UPDATE
  } avlm_state_t;

endpackage

FILE: rtl/accel_vibration_level_meter.sv
// ----------------------------------------------------------------------------
// accel_vibration_level_meter
// Bit-serial vibration meter: sample magnitude, running average over a
// history, windowed sum of absolute deviations and a scaled level output.
// ----------------------------------------------------------------------------
//
//   channel   valid         stall         payload
//   --------  ------------  ------------  ---------------------------
//   sample    sample_valid  sample_stall  accel_x, accel_y, accel_z
//   level     level_valid   level_stall   vibration_level
//
// a request runs its phases in turn: shift-add squaring of the three axes,
// the root steps, restoring divide steps over DW bits, where
// DW = max(16 + clog2(HISTORY_DEPTH + 1), 21), and the bookkeeping states;
// no new sample is taken until the request is back in idle.
// synchronous reset clears the history, its running sum, the window and the
// level valid flag. a held result does not block new samples; only the request
// that emits a level waits, in its last step, while level_stall holds the old one.
//
module accel_vibration_level_meter
  import avlm_pkg::*;
#(
  parameter int HISTORY_DEPTH = 16,
  parameter int WINDOW_ITEMS  = 20
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      sample_valid,
  output logic                      sample_stall,
  input  logic signed [AXIS_W-1:0]  accel_x,
  input  logic signed [AXIS_W-1:0]  accel_y,
  input  logic signed [AXIS_W-1:0]  accel_z,
  output logic                      level_valid,
  input  logic                      level_stall,
  output logic [LEVEL_W-1:0]        vibration_level
);

  localparam int HSW    = MAG_W + $clog2(HISTORY_DEPTH);
  localparam int SUMW   = MAG_W + $clog2(HISTORY_DEPTH + 1);
  localparam int DW     = (SUMW > TOTAL_W) ? SUMW : TOTAL_W;
  localparam int CW     = $clog2(DW);
  localparam int DIVMAX = (HISTORY_DEPTH + 1 > LEVEL_DIVISOR) ? HISTORY_DEPTH + 1
                                                              : LEVEL_DIVISOR;
  localparam int DIVW   = $clog2(DIVMAX + 1);
  localparam int CNTW   = $clog2(WINDOW_ITEMS + 1);

  avlm_state_t state, state_next;

  logic [CW-1:0]         step;
  logic [1:0]            axis;
  logic [AXIS_W-1:0]     mplier, op1, op2;
  logic [SQ_W-1:0]       mcand, acc, acc_next;
  logic [SQ_W-1:0]       rad;
  logic [ROOT_REM_W-1:0] rrem, rrem_sh, rtrial;
  logic [MAG_W-1:0]      root;
  logic [MAG_W-1:0]      hist [HISTORY_DEPTH];
  logic [HSW-1:0]        hist_sum;
  logic [DW-1:0]         dq;
  logic [DIVW-1:0]       drem, divisor;
  logic [DIVW:0]         dshift;
  logic                  dge;
  logic [CNTW-1:0]       count;
  logic [TOTAL_W-1:0]    total;
  logic [TOTAL_W:0]      tsum;
  logic [MAG_W-1:0]      avg, dev;
  logic [AXIS_W-1:0]     abs_x, abs_y, abs_z;
  logic                  emit, load_level, accept;

  assign abs_x = accel_x[AXIS_W-1] ? AXIS_W'(~accel_x) + AXIS_W'(1) : AXIS_W'(accel_x);
  assign abs_y = accel_y[AXIS_W-1] ? AXIS_W'(~accel_y) + AXIS_W'(1) : AXIS_W'(accel_y);
  assign abs_z = accel_z[AXIS_W-1] ? AXIS_W'(~accel_z) + AXIS_W'(1) : AXIS_W'(accel_z);

  assign accept   = sample_valid && !sample_stall;
  assign emit     = (count == CNTW'(WINDOW_ITEMS));
  assign acc_next = mplier[0] ? acc + mcand : acc;

  // one root digit: bring down two radicand bits, try 4r+1
  assign rrem_sh = {rrem[ROOT_REM_W-3:0], rad[SQ_W-1:SQ_W-2]};
  assign rtrial  = ROOT_REM_W'({root, 2'b01});

  // restoring divide step
  assign dshift = {drem, dq[DW-1]};
  assign dge    = (dshift >= {1'b0, divisor});

  assign avg  = dq[MAG_W-1:0];
  assign dev  = (root >= avg) ? root - avg : avg - root;
  assign tsum = {1'b0, total} + (TOTAL_W+1)'(dev);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (accept) state_next = ST_SQUARE;
      ST_SQUARE: if (step == CW'(15) && axis == 2'd2) state_next = ST_ROOT;
      ST_ROOT:   if (step == CW'(15)) state_next = ST_HIST;
      ST_HIST:   state_next = ST_PREP;
      ST_PREP:   state_next = ST_DIVIDE;
      ST_DIVIDE: if (step == CW'(DW - 1)) state_next = ST_UPDATE;
      ST_UPDATE: if (!(emit && level_valid && level_stall)) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    sample_stall = 1'b1;
    load_level   = 1'b0;
    case (state)
      ST_IDLE:   sample_stall = 1'b0;
      ST_UPDATE: load_level   = emit && !(level_valid && level_stall);
      default: begin
        sample_stall = 1'b1;
        load_level   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // window state, history and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      total       <= '0;
      hist_sum    <= '0;
      level_valid <= 1'b0;
      for (int i = 0; i < HISTORY_DEPTH; i++) hist[i] <= '0;
    end else begin
      if (state == ST_HIST) begin
        hist[0] <= root;
        for (int i = 1; i < HISTORY_DEPTH; i++) hist[i] <= hist[i-1];
        hist_sum <= hist_sum + HSW'(root) - HSW'(hist[HISTORY_DEPTH-1]);
      end
      if (state == ST_UPDATE) begin
        if (emit) begin
          if (load_level) begin
            count <= '0;
            total <= '0;
          end
        end else begin
          count <= count + CNTW'(1);
          total <= tsum[TOTAL_W] ? {TOTAL_W{1'b1}} : tsum[TOTAL_W-1:0];
        end
      end
      if (load_level) begin
        level_valid <= 1'b1;
      end else if (!level_stall) begin
        level_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_level) begin
      vibration_level <= (|dq[DW-1:LEVEL_W]) ? {LEVEL_W{1'b1}} : dq[LEVEL_W-1:0];
    end
  end

  // serial datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          mplier <= abs_x;
          mcand  <= SQ_W'(abs_x);
          op1    <= abs_y;
          op2    <= abs_z;
          acc    <= '0;
          axis   <= '0;
          step   <= '0;
        end
      end
      ST_SQUARE: begin
        acc <= acc_next;
        if (step == CW'(15)) begin
          step   <= '0;
          axis   <= axis + 2'd1;
          mplier <= op1;
          mcand  <= SQ_W'(op1);
          op1    <= op2;
          rad    <= acc_next;
          rrem   <= '0;
          root   <= '0;
        end else begin
          step   <= step + CW'(1);
          mplier <= mplier >> 1;
          mcand  <= mcand << 1;
        end
      end
      ST_ROOT: begin
        rad  <= rad << 2;
        step <= (step == CW'(15)) ? '0 : step + CW'(1);
        if (rrem_sh >= rtrial) begin
          rrem <= rrem_sh - rtrial;
          root <= {root[MAG_W-2:0], 1'b1};
        end else begin
          rrem <= rrem_sh;
          root <= {root[MAG_W-2:0], 1'b0};
        end
      end
      ST_PREP: begin
        drem <= '0;
        step <= '0;
        if (emit) begin
          dq      <= DW'(total);
          divisor <= DIVW'(LEVEL_DIVISOR);
        end else begin
          // new magnitude plus the history, which already holds it once
          dq      <= DW'(hist_sum) + DW'(root);
          divisor <= DIVW'(HISTORY_DEPTH + 1);
        end
      end
      ST_DIVIDE: begin
        drem <= dge ? DIVW'(dshift - {1'b0, divisor}) : dshift[DIVW-1:0];
        dq   <= {dq[DW-2:0], dge};
        step <= step + CW'(1);
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNTW'(WINDOW_ITEMS))
    else $error("window count beyond window length");

  a_level_source: assert property (@(posedge clk) disable iff (rst)
    $rose(level_valid) |-> $past(state == ST_UPDATE && emit))
    else $error("level produced outside an emitting update");

  a_window_clear: assert property (@(posedge clk) disable iff (rst)
    $rose(level_valid) |-> (count == '0 && total == '0))
    else $error("window not cleared after emitting a level");

  a_accept_start: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_SQUARE && step == '0 && axis == 2'd0))
    else $error("accepted request did not start squaring");
`endif

endmodule

FILE: verif/tb_accel_vibration_level_meter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_accel_vibration_level_meter: self-checking bench for the vibration meter
// Drives a short table of corner samples, then quiet, shaking, full-range,
// corner and tiny motion. Expected levels come from a model of the block kept in
// the bench. Random gaps on both channels, plus one long hold on the level side.
// ----------------------------------------------------------------------------
module tb_accel_vibration_level_meter;
  import avlm_pkg::*;

  localparam int HIST_DEPTH       = 16;
  localparam int WINDOW_LEN       = 20;
  localparam int RESET_CYCLES     = 10;
  localparam int CYCLES_PER_REQ   = 89;
  localparam int RANDOM_ITEMS     = 529;
  localparam int HOLD_AT          = 150;
  localparam int HOLD_LEN         = 6000;
  localparam int WATCHDOG_LIMIT   = 20000;
  localparam int DIRECTED_N       = 21;
  localparam longint TOTAL_MAX    = (64'd1 << TOTAL_W) - 1;
  localparam longint LEVEL_MAX    = (64'd1 << LEVEL_W) - 1;

  typedef enum {PROF_QUIET, PROF_SHAKE, PROF_WILD, PROF_CORNER, PROF_TINY} motion_t;
  typedef enum {GAP_NONE, GAP_SHORT, GAP_BURSTY} gap_style_t;
  typedef enum {SINK_OPEN, SINK_CHOPPY, SINK_BURSTY} sink_style_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     sample_valid = 1'b0;
  logic                     sample_stall;
  logic signed [AXIS_W-1:0] accel_x = '0;
  logic signed [AXIS_W-1:0] accel_y = '0;
  logic signed [AXIS_W-1:0] accel_z = '0;
  logic                     level_valid;
  logic                     level_stall = 1'b0;
  logic [LEVEL_W-1:0]       vibration_level;

  // model state
  logic [MAG_W-1:0]   mag_history [HIST_DEPTH];
  int                 window_fill;
  logic [TOTAL_W-1:0] deviation_sum;
  logic [LEVEL_W-1:0] pending_levels [$];

  int errors           = 0;
  int samples_sent     = 0;
  int levels_predicted = 0;
  int levels_checked   = 0;
  int peak_magnitude   = 0;
  int idle_cycles      = 0;
  int blocked_in_hold  = 0;
  int hold_left        = 0;
  bit hold_done        = 1'b0;
  int burst_left       = 0;
  int sink_cycles      = 0;
  logic [LEVEL_W-1:0] level_want;

  gap_style_t  src_style  = GAP_NONE;
  sink_style_t sink_style = SINK_OPEN;

  motion_t motion;
  int base_x, base_y, base_z, noise_amp;
  int corner_vals [7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};

  // corner samples from reset; the last one closes the first window
  int directed_rows [DIRECTED_N][3] = '{
    '{0, 0, 0},
    '{-32768, -32768, -32768},
    '{32767, 32767, 32767},
    '{-32768, 0, 0},
    '{0, -32768, 0},
    '{0, 0, -32768},
    '{32767, 0, 0},
    '{0, 32767, 0},
    '{0, 0, 32767},
    '{-1, -1, -1},
    '{1, 1, 1},
    '{3, 4, 0},
    '{0, 3, -4},
    '{21845, -21846, 21845},
    '{-21846, 21845, -21846},
    '{0, 0, 1},
    '{2, 2, 1},
    '{16384, 0, 0},
    '{0, 0, 16384},
    '{-32768, 32767, -32768},
    '{100, -200, 300}
  };

  accel_vibration_level_meter #(
    .HISTORY_DEPTH (HIST_DEPTH),
    .WINDOW_ITEMS  (WINDOW_LEN)
  ) u_top (
    .clk             (clk),
    .rst             (rst),
    .sample_valid    (sample_valid),
    .sample_stall    (sample_stall),
    .accel_x         (accel_x),
    .accel_y         (accel_y),
    .accel_z         (accel_z),
    .level_valid     (level_valid),
    .level_stall     (level_stall),
    .vibration_level (vibration_level)
  );

  always #5 clk = ~clk;

  // binary search for the largest root whose square fits
  function automatic logic [MAG_W-1:0] floor_root(input longint unsigned n);
    longint unsigned trial;
    logic [MAG_W-1:0] root;
    root = '0;
    for (int b = MAG_W - 1; b >= 0; b--) begin
      trial = longint'(root) | (64'd1 << b);
      if (trial * trial <= n) root = trial[MAG_W-1:0];
    end
    return root;
  endfunction

  task automatic meter_predict(input logic signed [AXIS_W-1:0] ax, ay, az);
    longint sq_sum;
    longint mag_sum;
    longint avg;
    longint dev;
    longint level;
    logic [MAG_W-1:0] mag;
    sq_sum = longint'(ax) * ax + longint'(ay) * ay + longint'(az) * az;
    mag = floor_root(sq_sum);
    if (int'(mag) > peak_magnitude) peak_magnitude = int'(mag);
    for (int i = HIST_DEPTH - 1; i > 0; i--) mag_history[i] = mag_history[i-1];
    mag_history[0] = mag;
    // new magnitude counts once on its own and once in the history
    mag_sum = longint'(mag);
    for (int i = 0; i < HIST_DEPTH; i++) mag_sum += longint'(mag_history[i]);
    avg = mag_sum / (HIST_DEPTH + 1);
    if (window_fill < WINDOW_LEN) begin
      window_fill++;
      dev = (longint'(mag) >= avg) ? longint'(mag) - avg : avg - longint'(mag);
      if (longint'(deviation_sum) + dev > TOTAL_MAX) deviation_sum = TOTAL_W'(TOTAL_MAX);
      else deviation_sum = TOTAL_W'(longint'(deviation_sum) + dev);
    end else begin
      level = longint'(deviation_sum) / LEVEL_DIVISOR;
      if (level > LEVEL_MAX) level = LEVEL_MAX;
      pending_levels.push_back(level[LEVEL_W-1:0]);
      levels_predicted++;
      window_fill = 0;
      deviation_sum = '0;
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int wanted);
    $display("[%0t] level check: %s, got %0d want %0d", $time, what, got, wanted);
    errors++;
  endtask

  function automatic int pick_gap(input gap_style_t style);
    case (style)
      GAP_NONE:  return 0;
      GAP_SHORT: return $urandom_range(0, 3);
      default: begin
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 120);
        return $urandom_range(0, 2);
      end
    endcase
  endfunction

  // entered and left at a falling edge
  task automatic send_sample(input int ax, ay, az);
    int gap;
    if ($urandom_range(0, 29) == 0) src_style = gap_style_t'($urandom_range(0, 2));
    gap = pick_gap(src_style);
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    accel_x      <= ax[AXIS_W-1:0];
    accel_y      <= ay[AXIS_W-1:0];
    accel_z      <= az[AXIS_W-1:0];
    sample_valid <= 1'b1;
    do @(posedge clk); while (sample_stall);
    meter_predict(ax[AXIS_W-1:0], ay[AXIS_W-1:0], az[AXIS_W-1:0]);
    samples_sent++;
    @(negedge clk);
  endtask

  function automatic int make_axis(input int base, input int amp);
    int v;
    v = base + int'($urandom_range(0, 2 * amp)) - amp;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v;
  endfunction

  task automatic pick_motion();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) motion = PROF_QUIET;
    else if (r < 65) motion = PROF_SHAKE;
    else if (r < 80) motion = PROF_WILD;
    else if (r < 90) motion = PROF_CORNER;
    else motion = PROF_TINY;
    base_x = int'($urandom_range(0, 40000)) - 20000;
    base_y = int'($urandom_range(0, 40000)) - 20000;
    base_z = int'($urandom_range(0, 40000)) - 20000;
    noise_amp = (motion == PROF_QUIET) ? $urandom_range(0, 64) : $urandom_range(500, 20000);
  endtask

  task automatic send_random_sample();
    case (motion)
      PROF_QUIET, PROF_SHAKE:
        send_sample(make_axis(base_x, noise_amp), make_axis(base_y, noise_amp),
                    make_axis(base_z, noise_amp));
      PROF_WILD:
        send_sample(int'($urandom_range(0, 65535)) - 32768,
                    int'($urandom_range(0, 65535)) - 32768,
                    int'($urandom_range(0, 65535)) - 32768);
      PROF_CORNER:
        send_sample(corner_vals[$urandom_range(0, 6)], corner_vals[$urandom_range(0, 6)],
                    corner_vals[$urandom_range(0, 6)]);
      default:
        send_sample(int'($urandom_range(0, 16)) - 8, int'($urandom_range(0, 16)) - 8,
                    int'($urandom_range(0, 16)) - 8);
    endcase
  endtask

  // level side: random stall patterns plus one long hold so the meter backs up
  always @(negedge clk) begin
    sink_cycles++;
    if (sink_cycles % 500 == 0) sink_style = sink_style_t'($urandom_range(0, 2));
    if (!hold_done && samples_sent >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_LEN;
    end
    if (rst) begin
      level_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      level_stall <= 1'b1;
    end else if (burst_left > 0) begin
      burst_left--;
      level_stall <= 1'b1;
    end else begin
      case (sink_style)
        SINK_OPEN:   level_stall <= 1'b0;
        SINK_CHOPPY: level_stall <= ($urandom_range(0, 3) == 0);
        default: begin
          if ($urandom_range(0, 39) == 0) burst_left = $urandom_range(20, 150);
          level_stall <= ($urandom_range(0, 3) == 0);
        end
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && level_valid && !level_stall) begin
      levels_checked++;
      if (pending_levels.size() == 0) begin
        report_mismatch("level with nothing pending", int'(vibration_level), -1);
      end else begin
        level_want = pending_levels.pop_front();
        if (vibration_level !== level_want)
          report_mismatch("vibration_level", int'(vibration_level), int'(level_want));
      end
    end
  end

  always @(posedge clk) begin
    if (hold_left > 0 && sample_valid && sample_stall) blocked_in_hold++;
    if (rst || (sample_valid && !sample_stall) || (level_valid && !level_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog: no handshake for %0d cycles", $time, idle_cycles);
      $display("accel_vibration_level_meter verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    foreach (mag_history[i]) mag_history[i] = '0;
    window_fill   = 0;
    deviation_sum = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int r = 0; r < DIRECTED_N; r++)
      send_sample(directed_rows[r][0], directed_rows[r][1], directed_rows[r][2]);

    pick_motion();
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(0, 14) == 0) pick_motion();
      send_random_sample();
    end
    sample_valid <= 1'b0;

    while (pending_levels.size() != 0) @(posedge clk);
    repeat (3 * CYCLES_PER_REQ) @(posedge clk);
    if (pending_levels.size() != 0)
      report_mismatch("levels left over", pending_levels.size(), 0);

    $display("covered %0d samples (%0d from the corner table), %0d levels checked",
             samples_sent, DIRECTED_N, levels_checked);
    $display("peak magnitude %0d, sample side blocked %0d cycles during the level hold",
             peak_magnitude, blocked_in_hold);
    if (errors == 0) begin
      $display("accel_vibration_level_meter verification clean");
    end else begin
      $display("accel_vibration_level_meter verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/avlm_pkg.sv
rtl/accel_vibration_level_meter.sv
verif/tb_accel_vibration_level_meter.sv
